// ----- sv/distinct_word_counter_unit_assert.svh -----
// ---------------------------------------------------------------------------
// Assertion macros for the distinct word counter unit.
// ---------------------------------------------------------------------------
`ifndef DISTINCT_WORD_COUNTER_UNIT_ASSERT_SVH
`define DISTINCT_WORD_COUNTER_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock edge, idle in reset.
`define DWC_ASSERT_IMPLIES(name, pre, post) \
   name: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error("distinct_word_counter_unit: assertion failed");

// Next-cycle implication, sampled on the rising clock edge, idle in reset.
`define DWC_ASSERT_NEXT(name, pre, post) \
   name: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error("distinct_word_counter_unit: assertion failed");

`endif

// ----- sv/dwc_pkg.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// dwc_pkg
// Shared types, defaults and helpers of the distinct word counter unit.
// ---------------------------------------------------------------------------
package dwc_pkg;

   localparam int MAX_WORDS_DEFAULT = 64;
   localparam int MAX_LEN_DEFAULT   = 16;
   localparam int COUNT_MAX         = 127;
   localparam int COUNT_W           = 7;
   localparam int CHAR_W            = 8;

   typedef struct packed {
      logic [CHAR_W-1:0] character;
      logic              line_end;
   } dwc_req_type;

   typedef struct packed {
      logic [COUNT_W-1:0] distinct_count;
      logic               word_truncated;
      logic               table_full;
   } dwc_rsp_type;

   // ASCII upper or lower case letter.
   function automatic logic is_letter(input logic [CHAR_W-1:0] c);
      return ((c >= 8'h41) && (c <= 8'h5A)) || ((c >= 8'h61) && (c <= 8'h7A));
   endfunction

endpackage

// ----- sv/dwc_ram.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// dwc_ram
// Simple dual-port memory: one write port, one read port with registered data.
// ---------------------------------------------------------------------------
module dwc_ram #(
   parameter int DATA_W = 8,
   parameter int DEPTH  = 16,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- sv/distinct_word_counter_unit.sv -----
`timescale 1ns / 1ps
// A letter that is not the last of its line is taken in S_IDLE. A word end runs S_START,
//   then S_RD_LEN and S_CK_LEN for each stored word scanned, S_RD_BYTE and S_CK_BYTE
//   for each byte compared, and S_INSERT for a new word. Words go one at a time through
//   the single byte compare unit, and no character is taken until a word end is done.
// A line end loads the result register in S_EMIT, stalling while the last result waits.
// Synchronous reset clears state, counts and flags, not indices, result data or memories.
// ---------------------------------------------------------------------------
// distinct_word_counter_unit
// Counts the distinct words of a text line, one character per handshake.
// ---------------------------------------------------------------------------
module distinct_word_counter_unit #(
   parameter int MAX_WORDS = dwc_pkg::MAX_WORDS_DEFAULT,
   parameter int MAX_LEN   = dwc_pkg::MAX_LEN_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  dwc_pkg::dwc_req_type req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output dwc_pkg::dwc_rsp_type rsp_data
);
   import dwc_pkg::*;

   `include "distinct_word_counter_unit_assert.svh"

   localparam int SLOT_W   = $clog2(MAX_WORDS);
   localparam int STORED_W = $clog2(MAX_WORDS + 1);
   localparam int IDX_W    = $clog2(MAX_LEN);
   localparam int LEN_W    = $clog2(MAX_LEN + 1);
   localparam int STORE_DEPTH = MAX_WORDS * (2 ** IDX_W);

   typedef enum logic [7:0] {
      S_IDLE    = 8'b0000_0001,
      S_START   = 8'b0000_0010,
      S_RD_LEN  = 8'b0000_0100,
      S_CK_LEN  = 8'b0000_1000,
      S_RD_BYTE = 8'b0001_0000,
      S_CK_BYTE = 8'b0010_0000,
      S_INSERT  = 8'b0100_0000,
      S_EMIT    = 8'b1000_0000
   } dwc_state_type;

   dwc_state_type state_ff, state_in;
   logic [SLOT_W-1:0]   slot_ff, slot_in;
   logic [IDX_W-1:0]    idx_ff, idx_in;
   logic [STORED_W-1:0] stored_ff, stored_in;
   logic [LEN_W-1:0]    cur_len_ff, cur_len_in;
   logic                trunc_ff, trunc_in;
   logic                full_ff, full_in;
   logic                last_ff, last_in;
   logic                rsp_valid_ff, rsp_valid_in;
   dwc_rsp_type         rsp_data_ff, rsp_data_in;

   logic                   cur_we, store_we, len_we;
   logic [CHAR_W-1:0]      cur_rdata, store_rdata;
   logic [LEN_W-1:0]       len_rdata;
   logic                   emit_go;
   logic                   table_room;
   logic                   last_slot;
   logic [COUNT_W-1:0]     count_sat;
   dwc_state_type          done_state;

   // Letters go both to the word in progress and straight into the next free row,
   // so inserting a new word only needs its length written.
   dwc_ram #(.DATA_W(CHAR_W), .DEPTH(MAX_LEN)) u_cur_ram (
      .clock   (clock),
      .wr_en   (cur_we),
      .wr_addr (cur_len_ff[IDX_W-1:0]),
      .wr_data (req_data.character),
      .rd_addr (idx_ff),
      .rd_data (cur_rdata)
   );

   dwc_ram #(.DATA_W(CHAR_W), .DEPTH(STORE_DEPTH)) u_store_ram (
      .clock   (clock),
      .wr_en   (store_we),
      .wr_addr ({stored_ff[SLOT_W-1:0], cur_len_ff[IDX_W-1:0]}),
      .wr_data (req_data.character),
      .rd_addr ({slot_ff, idx_ff}),
      .rd_data (store_rdata)
   );

   dwc_ram #(.DATA_W(LEN_W), .DEPTH(MAX_WORDS)) u_len_ram (
      .clock   (clock),
      .wr_en   (len_we),
      .wr_addr (stored_ff[SLOT_W-1:0]),
      .wr_data (cur_len_ff),
      .rd_addr (slot_ff),
      .rd_data (len_rdata)
   );

   assign table_room = (stored_ff < STORED_W'(MAX_WORDS));
   assign last_slot  = ((STORED_W'(slot_ff) + STORED_W'(1)) == stored_ff);
   assign emit_go    = !rsp_valid_ff || rsp_ready;
   assign done_state = last_ff ? S_EMIT : S_IDLE;
   assign count_sat  = (32'(stored_ff) > 32'(COUNT_MAX)) ? COUNT_W'(COUNT_MAX)
                                                         : COUNT_W'(stored_ff);

   always_comb begin
      state_in     = state_ff;
      slot_in      = slot_ff;
      idx_in       = idx_ff;
      stored_in    = stored_ff;
      cur_len_in   = cur_len_ff;
      trunc_in     = trunc_ff;
      full_in      = full_ff;
      last_in      = last_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      cur_we       = 1'b0;
      store_we     = 1'b0;
      len_we       = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               last_in = req_data.line_end;
               if (is_letter(req_data.character)) begin
                  if (cur_len_ff < LEN_W'(MAX_LEN)) begin
                     cur_we     = 1'b1;
                     store_we   = table_room;
                     cur_len_in = cur_len_ff + LEN_W'(1);
                  end else begin
                     trunc_in = 1'b1;
                  end
               end
               if (!is_letter(req_data.character) || req_data.line_end) begin
                  state_in = S_START;
               end
            end
         end
         S_START: begin
            if (cur_len_ff == '0) begin
               state_in = done_state;
            end else if (stored_ff == '0) begin
               state_in = S_INSERT;
            end else begin
               slot_in  = '0;
               state_in = S_RD_LEN;
            end
         end
         S_RD_LEN: begin
            state_in = S_CK_LEN;
         end
         S_CK_LEN: begin
            if (len_rdata == cur_len_ff) begin
               idx_in   = '0;
               state_in = S_RD_BYTE;
            end else if (last_slot) begin
               state_in = S_INSERT;
            end else begin
               slot_in  = slot_ff + SLOT_W'(1);
               state_in = S_RD_LEN;
            end
         end
         S_RD_BYTE: begin
            state_in = S_CK_BYTE;
         end
         S_CK_BYTE: begin
            if (cur_rdata != store_rdata) begin
               if (last_slot) begin
                  state_in = S_INSERT;
               end else begin
                  slot_in  = slot_ff + SLOT_W'(1);
                  state_in = S_RD_LEN;
               end
            end else if ((LEN_W'(idx_ff) + LEN_W'(1)) == cur_len_ff) begin
               // Repeat of a stored word: drop it.
               cur_len_in = '0;
               state_in   = done_state;
            end else begin
               idx_in   = idx_ff + IDX_W'(1);
               state_in = S_RD_BYTE;
            end
         end
         S_INSERT: begin
            if (table_room) begin
               len_we    = 1'b1;
               stored_in = stored_ff + STORED_W'(1);
            end else begin
               full_in = 1'b1;
            end
            cur_len_in = '0;
            state_in   = done_state;
         end
         S_EMIT: begin
            if (emit_go) begin
               rsp_valid_in               = 1'b1;
               rsp_data_in.distinct_count = count_sat;
               rsp_data_in.word_truncated = trunc_ff;
               rsp_data_in.table_full     = full_ff;
               stored_in                  = '0;
               cur_len_in                 = '0;
               trunc_in                   = 1'b0;
               full_in                    = 1'b0;
               state_in                   = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         stored_ff    <= '0;
         cur_len_ff   <= '0;
         trunc_ff     <= 1'b0;
         full_ff      <= 1'b0;
         last_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         stored_ff    <= stored_in;
         cur_len_ff   <= cur_len_in;
         trunc_ff     <= trunc_in;
         full_ff      <= full_in;
         last_ff      <= last_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      slot_ff     <= slot_in;
      idx_ff      <= idx_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `DWC_ASSERT_IMPLIES(a_stored_bound, 1'b1, stored_ff <= STORED_W'(MAX_WORDS))
   `DWC_ASSERT_IMPLIES(a_len_bound, 1'b1, cur_len_ff <= LEN_W'(MAX_LEN))
   `DWC_ASSERT_IMPLIES(a_byte_idx, state_ff == S_CK_BYTE, LEN_W'(idx_ff) < cur_len_ff)
   `DWC_ASSERT_IMPLIES(a_scan_slot, state_ff == S_CK_LEN, STORED_W'(slot_ff) < stored_ff)
   `DWC_ASSERT_NEXT(a_emit_clears, (state_ff == S_EMIT) && emit_go, rsp_valid_ff && (stored_ff == '0))

endmodule
